/* hw/rtl/hsl_pkg.sv */
// ----------------------------------------------------------------------------
// hsl_pkg
// Types and constants shared by the HSL to RGB pixel pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

  localparam int CHROMA_W    = 24;
  localparam int PROD_W      = 31;
  localparam int RECIP_SHIFT = 38;

  localparam logic [31:0]         RECIP_85   = 32'hC0C0C0C1;
  localparam logic [CHROMA_W-1:0] MAX_CHROMA = 24'hFF0000;

  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR
  } sector_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;
    logic [7:0] alpha;
  } pix_hsl_t;

  typedef struct packed {
    sector_t    sector;
    logic [6:0] f;
    logic [15:0] p;
    logic [7:0] lightness;
    logic [7:0] alpha;
  } chroma_in_t;

  typedef struct packed {
    sector_t             sector;
    logic [6:0]          f;
    logic [CHROMA_W-1:0] chroma;
    logic [7:0]          lightness;
    logic [7:0]          alpha;
  } chroma_t;

  typedef struct packed {
    sector_t             sector;
    logic [PROD_W-1:0]   y;
    logic [CHROMA_W-1:0] chroma;
    logic [7:0]          lightness;
    logic [7:0]          alpha;
  } prod_t;

  typedef struct packed {
    sector_t             sector;
    logic [CHROMA_W-1:0] second;
    logic [CHROMA_W-1:0] chroma;
    logic [7:0]          lightness;
    logic [7:0]          alpha;
  } comp_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_rgb_t;

endpackage

/* hw/rtl/hsl_in_if.sv */
// ----------------------------------------------------------------------------
// hsl_in_if
// Input channel carrying one HSL pixel item with alpha.
// ----------------------------------------------------------------------------
interface hsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] lightness;
  logic [7:0] alpha_in;

  modport source (output valid, output hue, output saturation, output lightness,
                  output alpha_in, input ready);
  modport sink (input valid, input hue, input saturation, input lightness,
                input alpha_in, output ready);
endinterface

/* hw/rtl/hsl_out_if.sv */
// ----------------------------------------------------------------------------
// hsl_out_if
// Output channel carrying one RGB pixel item with alpha.
// ----------------------------------------------------------------------------
interface hsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha_out;

  modport source (output valid, output red, output green, output blue,
                  output alpha_out, input ready);
  modport sink (input valid, input red, input green, input blue,
                input alpha_out, output ready);
endinterface

/* hw/rtl/hsl_to_rgb_pixel.sv */
// ----------------------------------------------------------------------------
// hsl_to_rgb_pixel
// Converts 8-bit hue, saturation and lightness pixels to 8-bit RGB with
// alpha carried alongside.
// ----------------------------------------------------------------------------
// Usage: items enter on in_px (hue, saturation, lightness, alpha_in) and
// leave on out_px (red, green, blue, alpha_out), each channel taking an item
// on a clock edge where valid and ready are both high.
// An accepted item reaches out_px.valid through five register stages: two
// form chroma, two form the secondary component through a reciprocal
// multiply by 1/85, and one output register mixes, offsets and clamps.
// Throughput is one item per cycle while out_px.ready stays high; the 32-bit
// reciprocal multiply sets the longest path.
// Each stage has its own valid bit and loads whenever it is empty or the
// next stage takes its item, so bubbles are squeezed out while the receiver
// stalls and up to five items wait in the pipeline before in_px.ready falls.
// A stalled output item holds steady until taken.
// Reset is synchronous and active low; it empties every stage at once and
// the block accepts items on the cycle after reset is released.
// ----------------------------------------------------------------------------
module hsl_to_rgb_pixel
  import hsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  hsl_in_if.sink    in_px,
  hsl_out_if.source out_px
);

  pix_hsl_t in_data;
  logic     c_valid;
  logic     c_ready;
  chroma_t  c_data;
  logic     s_valid;
  logic     s_ready;
  comp_t    s_data;
  pix_rgb_t o_data;

  assign in_data.hue        = in_px.hue;
  assign in_data.saturation = in_px.saturation;
  assign in_data.lightness  = in_px.lightness;
  assign in_data.alpha      = in_px.alpha_in;

  hsl_chroma u_chroma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_ready  (in_px.ready),
    .in_data   (in_data),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_data  (c_data)
  );

  hsl_second u_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_data   (c_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  hsl_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .out_valid (out_px.valid),
    .out_ready (out_px.ready),
    .out_data  (o_data)
  );

  assign out_px.red       = o_data.red;
  assign out_px.green     = o_data.green;
  assign out_px.blue      = o_data.blue;
  assign out_px.alpha_out = o_data.alpha;

endmodule

/* hw/rtl/hsl_chroma.sv */
// ----------------------------------------------------------------------------
// hsl_chroma
// Two pipeline stages: sector, hue ramp and lightness span product, then
// chroma in Q.16 by a reciprocal divide by 255.
// ----------------------------------------------------------------------------
module hsl_chroma
  import hsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pix_hsl_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output chroma_t  out_data
);

  logic       s1_v_r;
  chroma_in_t s1_r;
  chroma_in_t s1_nxt;
  logic       s2_v_r;
  chroma_t    s2_r;
  chroma_t    s2_nxt;
  logic       s1_ready;
  logic       s2_ready;

  logic [8:0]  l2;
  logic [8:0]  d;
  logic [7:0]  span;
  logic [8:0]  h2;
  logic [8:0]  t;
  logic [8:0]  ramp_dev;
  logic [16:0] qsum;
  logic [7:0]  q;

  assign s2_ready = !s2_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    l2   = {in_data.lightness, 1'b0};
    d    = (l2 >= 9'd255) ? (l2 - 9'd255) : (9'd255 - l2);
    span = 8'd255 - d[7:0];
    h2   = {in_data.hue, 1'b0};
    if (h2 < 9'd85) begin
      s1_nxt.sector = SEC_RY;
    end else if (h2 < 9'd170) begin
      s1_nxt.sector = SEC_YG;
    end else if (h2 < 9'd255) begin
      s1_nxt.sector = SEC_GC;
    end else if (h2 < 9'd340) begin
      s1_nxt.sector = SEC_CB;
    end else if (h2 < 9'd425) begin
      s1_nxt.sector = SEC_BM;
    end else begin
      s1_nxt.sector = SEC_MR;
    end
    if (h2 < 9'd170) begin
      t = h2;
    end else if (h2 < 9'd340) begin
      t = h2 - 9'd170;
    end else begin
      t = h2 - 9'd340;
    end
    ramp_dev         = (t >= 9'd85) ? (t - 9'd85) : (9'd85 - t);
    s1_nxt.f         = 7'(9'd85 - ramp_dev);
    s1_nxt.p         = 16'(span) * 16'(in_data.saturation);
    s1_nxt.lightness = in_data.lightness;
    s1_nxt.alpha     = in_data.alpha;
  end

  // The product is at most 255 * 255, where (x + x/256 + 1) / 256 gives x / 255 exactly.
  always_comb begin
    qsum             = 17'(s1_r.p) + 17'(s1_r.p[15:8]) + 17'd1;
    q                = qsum[15:8];
    s2_nxt.sector    = s1_r.sector;
    s2_nxt.f         = s1_r.f;
    s2_nxt.chroma    = {s1_r.p, 8'd0} + CHROMA_W'(s1_r.p) + CHROMA_W'(q);
    s2_nxt.lightness = s1_r.lightness;
    s2_nxt.alpha     = s1_r.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
    if (s1_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

`ifndef SYNTHESIS
  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (s2_r.chroma <= MAX_CHROMA))
    else $error("chroma above full scale");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_ready) |=> (s1_v_r && $stable(s1_r)))
    else $error("stalled first stage item changed");
`endif

endmodule

/* hw/rtl/hsl_second.sv */
// ----------------------------------------------------------------------------
// hsl_second
// Two pipeline stages forming the secondary component: chroma times the hue
// ramp, then division by 85 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module hsl_second
  import hsl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  chroma_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output comp_t   out_data
);

  localparam int WIDE_W = PROD_W + 32;

  logic  s3_v_r;
  prod_t s3_r;
  prod_t s3_nxt;
  logic  s4_v_r;
  comp_t s4_r;
  comp_t s4_nxt;
  logic  s3_ready;
  logic  s4_ready;
  logic [WIDE_W-1:0] wide;

  assign s4_ready = !s4_v_r || out_ready;
  assign s3_ready = !s3_v_r || s4_ready;
  assign in_ready = s3_ready;

  always_comb begin
    s3_nxt.sector    = in_data.sector;
    s3_nxt.y         = PROD_W'(in_data.chroma) * PROD_W'(in_data.f);
    s3_nxt.chroma    = in_data.chroma;
    s3_nxt.lightness = in_data.lightness;
    s3_nxt.alpha     = in_data.alpha;
  end

  always_comb begin
    wide             = WIDE_W'(s3_r.y) * WIDE_W'(RECIP_85);
    s4_nxt.sector    = s3_r.sector;
    s4_nxt.second    = wide[RECIP_SHIFT +: CHROMA_W];
    s4_nxt.chroma    = s3_r.chroma;
    s4_nxt.lightness = s3_r.lightness;
    s4_nxt.alpha     = s3_r.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_v_r <= in_valid;
      end
      if (s4_ready) begin
        s4_v_r <= s3_v_r;
      end
    end
    if (s3_ready && in_valid) begin
      s3_r <= s3_nxt;
    end
    if (s4_ready && s3_v_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign out_valid = s4_v_r;
  assign out_data  = s4_r;

`ifndef SYNTHESIS
  a_second_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (s4_r.second <= s4_r.chroma))
    else $error("secondary component exceeds chroma");
`endif

endmodule

/* hw/rtl/hsl_mix.sv */
// ----------------------------------------------------------------------------
// hsl_mix
// Output stage: places chroma and the secondary component by sector, adds
// the lightness offset and clamps each channel to eight bits.
// ----------------------------------------------------------------------------
module hsl_mix
  import hsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  comp_t    in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pix_rgb_t out_data
);

  localparam int SUM_W = CHROMA_W + 3;

  logic                o_v_r;
  pix_rgb_t            o_r;
  pix_rgb_t            o_nxt;
  logic [CHROMA_W-1:0] r_c;
  logic [CHROMA_W-1:0] g_c;
  logic [CHROMA_W-1:0] b_c;
  logic signed [SUM_W-1:0] offset;

  function automatic logic [7:0] clamp_ch(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-17:0] whole;
    whole = v[SUM_W-1:16];
    if (v < 0) begin
      return 8'd0;
    end else if (whole > (SUM_W-16)'(255)) begin
      return 8'd255;
    end else begin
      return whole[7:0];
    end
  endfunction

  assign in_ready = !o_v_r || out_ready;

  always_comb begin
    r_c = '0;
    g_c = '0;
    b_c = '0;
    case (in_data.sector)
      SEC_RY: begin
        r_c = in_data.chroma;
        g_c = in_data.second;
      end
      SEC_YG: begin
        r_c = in_data.second;
        g_c = in_data.chroma;
      end
      SEC_GC: begin
        g_c = in_data.chroma;
        b_c = in_data.second;
      end
      SEC_CB: begin
        g_c = in_data.second;
        b_c = in_data.chroma;
      end
      SEC_BM: begin
        r_c = in_data.second;
        b_c = in_data.chroma;
      end
      default: begin
        r_c = in_data.chroma;
        b_c = in_data.second;
      end
    endcase
    offset = $signed({3'd0, in_data.lightness, 16'd0})
           - $signed(SUM_W'(in_data.chroma[CHROMA_W-1:1]));
    o_nxt.red   = clamp_ch(offset + $signed(SUM_W'(r_c)));
    o_nxt.green = clamp_ch(offset + $signed(SUM_W'(g_c)));
    o_nxt.blue  = clamp_ch(offset + $signed(SUM_W'(b_c)));
    o_nxt.alpha = in_data.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (in_ready) begin
      o_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

`ifndef SYNTHESIS
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.chroma == '0)) |=>
      ((o_r.red == o_r.green) && (o_r.green == o_r.blue)))
    else $error("zero chroma item did not give equal channels");
`endif

endmodule

/* tb/hsl_to_rgb_pixel_test.sv */
// ----------------------------------------------------------------------------
// hsl_to_rgb_pixel_test
// Self-checking bench for the HSL to RGB pixel converter. Every accepted
// pixel is converted by an independent fixed-point predictor and queued; each
// pixel leaving the block is compared field by field with the oldest entry.
// Directed corner pixels come first, then random pixels under random stalls on
// both channels, one long output hold-off, and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class rgb_scoreboard;
  hsl_pkg::pix_rgb_t expected_q[$];
  int unsigned       mismatches;

  function new();
    mismatches = 0;
  endfunction

  function automatic logic [7:0] clamp_q16(longint q);
    longint whole;
    if (q < 0) return 8'd0;
    whole = q >>> 16;
    if (whole > 255) return 8'd255;
    return whole[7:0];
  endfunction

  function automatic hsl_pkg::pix_rgb_t convert_hsl(hsl_pkg::pix_hsl_t px);
    logic [63:0]      lit, sat, hue2, l2, dist_l, chroma, wrap, dist_h, f, second;
    longint           offset, half, red_c, green_c, blue_c;
    hsl_pkg::sector_t sector;
    hsl_pkg::pix_rgb_t res;
    lit    = 64'(px.lightness);
    sat    = 64'(px.saturation);
    hue2   = 64'(px.hue);
    hue2   = hue2 * 2;
    l2     = lit * 2;
    dist_l = (l2 >= 255) ? l2 - 255 : 255 - l2;
    chroma = (((255 - dist_l) * sat) << 16) / 255;
    wrap   = hue2 % 170;
    dist_h = (wrap >= 85) ? wrap - 85 : 85 - wrap;
    f      = 85 - dist_h;
    second = (chroma * f) / 85;
    half   = chroma >> 1;
    offset = lit << 16;
    offset = offset - half;
    if (hue2 < 85)       sector = hsl_pkg::SEC_RY;
    else if (hue2 < 170) sector = hsl_pkg::SEC_YG;
    else if (hue2 < 255) sector = hsl_pkg::SEC_GC;
    else if (hue2 < 340) sector = hsl_pkg::SEC_CB;
    else if (hue2 < 425) sector = hsl_pkg::SEC_BM;
    else                 sector = hsl_pkg::SEC_MR;
    red_c   = 0;
    green_c = 0;
    blue_c  = 0;
    case (sector)
      hsl_pkg::SEC_RY: begin
        red_c   = chroma;
        green_c = second;
      end
      hsl_pkg::SEC_YG: begin
        red_c   = second;
        green_c = chroma;
      end
      hsl_pkg::SEC_GC: begin
        green_c = chroma;
        blue_c  = second;
      end
      hsl_pkg::SEC_CB: begin
        green_c = second;
        blue_c  = chroma;
      end
      hsl_pkg::SEC_BM: begin
        red_c  = second;
        blue_c = chroma;
      end
      default: begin
        red_c  = chroma;
        blue_c = second;
      end
    endcase
    res.red   = clamp_q16(red_c + offset);
    res.green = clamp_q16(green_c + offset);
    res.blue  = clamp_q16(blue_c + offset);
    res.alpha = px.alpha;
    return res;
  endfunction

  function void note_pixel(hsl_pkg::pix_hsl_t px);
    expected_q.push_back(convert_hsl(px));
  endfunction

  task report(string msg);
    if (mismatches < 100) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task check_pixel(hsl_pkg::pix_rgb_t got);
    hsl_pkg::pix_rgb_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected pixel r=%0d g=%0d b=%0d a=%0d",
                       got.red, got.green, got.blue, got.alpha));
    end else begin
      want = expected_q.pop_front();
      if (got.red !== want.red)
        report($sformatf("red %0d, expected %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green %0d, expected %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue %0d, expected %0d", got.blue, want.blue));
      if (got.alpha !== want.alpha)
        report($sformatf("alpha %0d, expected %0d", got.alpha, want.alpha));
    end
  endtask
endclass

module hsl_to_rgb_pixel_test;
  import hsl_pkg::*;

  localparam int NUM_RANDOM   = 900;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AFTER   = 120;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 1000;

  logic clk;
  logic rst_n;
  logic quiet;
  logic hold_active;
  int   accepted_in;
  int   stall_cycles;

  rgb_scoreboard sb;

  hsl_in_if  in_px();
  hsl_out_if out_px();

  hsl_to_rgb_pixel u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    pix_hsl_t px_in;
    pix_rgb_t px_out;
    if (rst_n && in_px.valid && in_px.ready) begin
      px_in.hue        = in_px.hue;
      px_in.saturation = in_px.saturation;
      px_in.lightness  = in_px.lightness;
      px_in.alpha      = in_px.alpha_in;
      sb.note_pixel(px_in);
      accepted_in <= accepted_in + 1;
    end
    if (rst_n && out_px.valid && out_px.ready) begin
      px_out.red   = out_px.red;
      px_out.green = out_px.green;
      px_out.blue  = out_px.blue;
      px_out.alpha = out_px.alpha_out;
      sb.check_pixel(px_out);
    end
    if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    sb.report($sformatf("watchdog: nothing moved for %0d cycles", STALL_LIMIT));
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off that fills the block.
  initial begin
    int  gap;
    bit  held;
    held = 1'b0;
    out_px.ready <= 1'b1;
    hold_active  <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && accepted_in >= HOLD_AFTER) begin
        held = 1'b1;
        hold_active  <= 1'b1;
        out_px.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active  <= 1'b0;
        out_px.ready <= 1'b1;
      end else if (rst_n && !quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 17);
        out_px.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_px.ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [7:0] h, input logic [7:0] s,
                            input logic [7:0] l, input logic [7:0] a);
    int gap;
    in_px.valid      <= 1'b1;
    in_px.hue        <= h;
    in_px.saturation <= s;
    in_px.lightness  <= l;
    in_px.alpha_in   <= a;
    do @(posedge clk); while (!in_px.ready);
    if (!quiet && !hold_active && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_px.valid      <= 1'b0;
      in_px.hue        <= 8'($urandom);
      in_px.saturation <= 8'($urandom);
      in_px.lightness  <= 8'($urandom);
      in_px.alpha_in   <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_level(input int unsigned sel);
    case (sel)
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0] h, s, l, a;
    sb = new();
    rst_n            <= 1'b0;
    quiet            <= 1'b0;
    accepted_in      <= 0;
    stall_cycles     <= 0;
    in_px.valid      <= 1'b0;
    in_px.hue        <= 8'd0;
    in_px.saturation <= 8'd0;
    in_px.lightness  <= 8'd0;
    in_px.alpha_in   <= 8'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd100, 8'd0,   8'd77,  8'd170);
    send_pixel(8'd200, 8'd0,   8'd200, 8'd85);
    send_pixel(8'd0,   8'd255, 8'd127, 8'd1);
    send_pixel(8'd0,   8'd255, 8'd128, 8'd2);
    send_pixel(8'd30,  8'd255, 8'd0,   8'd4);
    send_pixel(8'd30,  8'd255, 8'd255, 8'd8);
    send_pixel(8'd42,  8'd255, 8'd128, 8'd16);
    send_pixel(8'd43,  8'd255, 8'd128, 8'd32);
    send_pixel(8'd84,  8'd255, 8'd128, 8'd64);
    send_pixel(8'd85,  8'd255, 8'd128, 8'd128);
    send_pixel(8'd127, 8'd255, 8'd128, 8'd254);
    send_pixel(8'd128, 8'd255, 8'd128, 8'd253);
    send_pixel(8'd169, 8'd255, 8'd128, 8'd251);
    send_pixel(8'd170, 8'd255, 8'd128, 8'd247);
    send_pixel(8'd212, 8'd255, 8'd128, 8'd239);
    send_pixel(8'd213, 8'd255, 8'd128, 8'd223);
    send_pixel(8'd255, 8'd255, 8'd128, 8'd191);
    send_pixel(8'd21,  8'd200, 8'd60,  8'd127);
    send_pixel(8'd150, 8'd128, 8'd190, 8'd0);
    send_pixel(8'd64,  8'd1,   8'd1,   8'd255);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - QUIET_TAIL) quiet <= 1'b1;
      h = 8'($urandom_range(0, 255));
      s = pick_level($urandom_range(0, 9));
      l = pick_level($urandom_range(0, 9));
      a = 8'($urandom_range(0, 255));
      send_pixel(h, s, l, a);
    end
    in_px.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d pixels never came out", sb.expected_q.size()));
    if (sb.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
